// ----- src/ssl_pkg.sv -----
// Shared types and constants for the sorted sparse term list.
package ssl_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned MOVES_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  localparam logic [2:0] MODE_READ = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_ORDERED = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [15:0]        row;
    logic [15:0]        col;
    logic signed [31:0] val;
  } term_t;

  localparam int unsigned TERM_W = $bits(term_t);

endpackage

// ----- src/ssl_in_if.sv -----
// Input channel of the sorted sparse term list: one operation word.
interface ssl_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [5:0]         index;
  logic [15:0]        row;
  logic [15:0]        col;
  logic signed [31:0] val;

  modport source (output valid, mode, index, row, col, val, input ready);
  modport sink (input valid, mode, index, row, col, val, output ready);
endinterface

// ----- src/ssl_out_if.sv -----
// Result channel of the sorted sparse term list: one result word.
interface ssl_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [15:0]        out_row;
  logic [15:0]        out_col;
  logic signed [31:0] out_val;
  logic [6:0]         count;
  logic [31:0]        moves;

  modport source (output valid, status, out_row, out_col, out_val, count, moves,
                  input ready);
  modport sink (input valid, status, out_row, out_col, out_val, count, moves,
                output ready);
endinterface

// ----- src/ssl_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ssl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/sorted_sparse_term_list.sv -----
// Top level of the sorted sparse term list: control, counters and term memory.
//
//   Channel   Direction  Handshake        Word
//   in_ch     in         valid / ready    mode, index, row, col, val
//   out_ch    out        valid / ready    status, out_row, out_col, out_val, count, moves
//   cfg       in         cfg_we only      cfg_wdata (capacity)
//
// One operation is worked at a time; the input is ready only in the idle state.
// Read passes through the read-data state; clear, unused modes and errors go straight to emit;
// delete shifts later entries down one place, insert shifts them up and then writes the term.
// Ordered insert first scans for the first entry whose row, col key is greater than the new one.
// Reset clears the count and the shift total and sets the capacity to 64, not the terms.
// A finished result waits in the output register; a stalled result holds the emit state.
module sorted_sparse_term_list
  import ssl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  ssl_in_if.sink           in_ch,
  ssl_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDATA,
    ST_DEL0,
    ST_DN,
    ST_SCAN,
    ST_CMP,
    ST_UP,
    ST_EMIT
  } state_t;

  state_t st_r, st_nxt;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MOVES_W-1:0] moves_r, moves_nxt;
  logic [CNT_W-1:0]   cap_r;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   wa_r, wa_nxt;
  logic               wpend_r, wpend_nxt;
  term_t              term_r, term_nxt;
  term_t              res_r, res_nxt;
  logic [1:0]         stat_r, stat_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  term_t              out_term_r, out_term_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;
  logic [MOVES_W-1:0] out_moves_r, out_moves_nxt;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  term_t              mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [TERM_W-1:0]  mem_rdata;
  term_t              rd_term;

  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   add_n;
  logic               add_en;
  logic [MOVES_W:0]   moves_sum;
  logic               key_gt;
  logic               in_fire;

  ssl_ram #(
    .WIDTH (TERM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_term = term_t'(mem_rdata);
  assign limit = (cap_r >= CNT_MAX) ? CNT_MAX : cap_r;
  assign in_ch.ready = (st_r == ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign key_gt = (rd_term.row > term_r.row) ||
                  ((rd_term.row == term_r.row) && (rd_term.col > term_r.col));
  assign moves_sum = {1'b0, moves_r} + {{(MOVES_W + 1 - CNT_W){1'b0}}, add_n};

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    moves_nxt = moves_r;
    ptr_nxt = ptr_r;
    pos_nxt = pos_r;
    idx_nxt = idx_r;
    wa_nxt = wa_r;
    wpend_nxt = wpend_r;
    term_nxt = term_r;
    res_nxt = res_r;
    stat_nxt = stat_r;
    mem_we = 1'b0;
    mem_waddr = wa_r;
    mem_wdata = rd_term;
    mem_raddr = ptr_r[IDX_W-1:0];
    add_n = '0;
    add_en = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_term_nxt = out_term_r;
    out_count_nxt = out_count_r;
    out_moves_nxt = out_moves_r;

    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt = in_ch.index;
          term_nxt = '{row: in_ch.row, col: in_ch.col, val: in_ch.val};
          res_nxt = '0;
          stat_nxt = STAT_OK;
          wpend_nxt = 1'b0;
          st_nxt = ST_EMIT;
          unique case (in_ch.mode)
            MODE_READ: begin
              mem_raddr = in_ch.index;
              if ({1'b0, in_ch.index} >= cnt_r) begin
                stat_nxt = STAT_RANGE;
              end else begin
                st_nxt = ST_RDATA;
              end
            end
            MODE_INSERT: begin
              if ({1'b0, in_ch.index} > cnt_r) begin
                stat_nxt = STAT_RANGE;
              end else if (cnt_r >= limit) begin
                stat_nxt = STAT_FULL;
              end else begin
                pos_nxt = {1'b0, in_ch.index};
                ptr_nxt = cnt_r;
                st_nxt = ST_UP;
              end
            end
            MODE_DELETE: begin
              mem_raddr = in_ch.index;
              if ({1'b0, in_ch.index} >= cnt_r) begin
                stat_nxt = STAT_RANGE;
              end else begin
                ptr_nxt = {1'b0, in_ch.index} + 1'b1;
                st_nxt = ST_DEL0;
              end
            end
            MODE_ORDERED: begin
              if (cnt_r >= limit) begin
                stat_nxt = STAT_FULL;
              end else begin
                ptr_nxt = '0;
                st_nxt = ST_SCAN;
              end
            end
            MODE_CLEAR: begin
              cnt_nxt = '0;
              moves_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RDATA: begin
        res_nxt = rd_term;
        st_nxt = ST_EMIT;
      end
      ST_DEL0: begin
        res_nxt = rd_term;
        st_nxt = ST_DN;
      end
      ST_DN: begin
        if (wpend_r) begin
          mem_we = 1'b1;
        end
        wpend_nxt = 1'b0;
        if (ptr_r < cnt_r) begin
          wpend_nxt = 1'b1;
          wa_nxt = ptr_r[IDX_W-1:0] - 1'b1;
          ptr_nxt = ptr_r + 1'b1;
        end else if (!wpend_r) begin
          add_n = cnt_r - {1'b0, idx_r} - 1'b1;
          add_en = 1'b1;
          cnt_nxt = cnt_r - 1'b1;
          st_nxt = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (ptr_r < cnt_r) begin
          st_nxt = ST_CMP;
        end else begin
          pos_nxt = cnt_r;
          ptr_nxt = cnt_r;
          st_nxt = ST_UP;
        end
      end
      ST_CMP: begin
        if (key_gt) begin
          pos_nxt = ptr_r;
          ptr_nxt = cnt_r;
          st_nxt = ST_UP;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
          st_nxt = ST_SCAN;
        end
      end
      ST_UP: begin
        mem_raddr = ptr_r[IDX_W-1:0] - 1'b1;
        if (wpend_r) begin
          mem_we = 1'b1;
        end
        wpend_nxt = 1'b0;
        if (ptr_r > pos_r) begin
          wpend_nxt = 1'b1;
          wa_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt = ptr_r - 1'b1;
        end else if (!wpend_r) begin
          mem_we = 1'b1;
          mem_waddr = pos_r[IDX_W-1:0];
          mem_wdata = term_r;
          add_n = cnt_r - pos_r;
          add_en = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = stat_r;
          out_term_nxt = res_r;
          out_count_nxt = cnt_r;
          out_moves_nxt = moves_r;
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (add_en) begin
      moves_nxt = moves_sum[MOVES_W] ? '1 : moves_sum[MOVES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r <= '0;
      moves_r <= '0;
      cap_r <= CAP_RESET;
      wpend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      moves_r <= moves_nxt;
      wpend_r <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
    ptr_r <= ptr_nxt;
    pos_r <= pos_nxt;
    idx_r <= idx_nxt;
    wa_r <= wa_nxt;
    term_r <= term_nxt;
    res_r <= res_nxt;
    stat_r <= stat_nxt;
    out_status_r <= out_status_nxt;
    out_term_r <= out_term_nxt;
    out_count_r <= out_count_nxt;
    out_moves_r <= out_moves_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.out_row = out_term_r.row;
  assign out_ch.out_col = out_term_r.col;
  assign out_ch.out_val = out_term_r.val;
  assign out_ch.count = out_count_r;
  assign out_ch.moves = out_moves_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("entry count exceeds the memory depth");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> !wpend_r)
    else $error("memory write left pending at the end of an operation");

  a_error_zero_term: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_EMIT) && (stat_r != STAT_OK)) |-> (res_r == '0))
    else $error("error result carries a nonzero term");

  a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_UP) && (cnt_r >= CNT_MAX)) |-> !mem_we)
    else $error("insert proceeding on a full memory");

endmodule
